// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Asserts that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfc_pkg.sv =====
// Package with the request types, status codes and CRC-8 function of the frame checker.
package sfc_pkg;

    localparam int FRAME_BYTES = 6;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [2:0] MAX_ATTEMPTS_RESET = 3'd3;
    localparam logic [2:0] LAST_POS = 3'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        KIND_START    = 2'd0,
        KIND_BYTE     = 2'd1,
        KIND_CMD_FAIL = 2'd2,
        KIND_RD_FAIL  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CRC  = 2'd1,
        ST_COMM = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_MAX_ATTEMPTS = 1'b0
    } reg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
    } sfc_in_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] raw_temperature;
        logic [15:0] raw_humidity;
    } sfc_out_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/sfc_frame.sv =====
// Frame state and result logic: CRC tracking, byte position and attempt counting.
module sfc_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sfc_pkg::sfc_in_t  item,
    input  logic [2:0]        max_attempts,
    output logic              res_valid,
    output sfc_pkg::sfc_out_t res
);
    import sfc_pkg::*;

    logic [7:0]  crc_reg,      crc_next;
    logic [2:0]  pos_reg,      pos_next;
    logic [2:0]  attempts_reg, attempts_next;
    logic        open_reg,     open_next;
    logic        bad_reg,      bad_next;
    logic [15:0] temp_reg,     temp_next;
    logic [15:0] hum_reg,      hum_next;
    logic [2:0]  attempts_inc;
    logic [7:0]  crc_fed;

    assign attempts_inc = attempts_reg + 3'd1;
    assign crc_fed = crc_feed(crc_reg, item.data_byte);

    always_comb
    begin
        crc_next = crc_reg;
        pos_next = pos_reg;
        attempts_next = attempts_reg;
        open_next = open_reg;
        bad_next = bad_reg;
        temp_next = temp_reg;
        hum_next = hum_reg;
        res_valid = 1'b0;
        res.status = ST_OK;
        res.raw_temperature = '0;
        res.raw_humidity = '0;
        case (item.kind)
            KIND_START:
            begin
                open_next = 1'b1;
                attempts_next = '0;
                crc_next = CRC_INIT;
                pos_next = '0;
                bad_next = 1'b0;
                temp_next = '0;
                hum_next = '0;
            end
            KIND_CMD_FAIL:
            begin
                open_next = 1'b0;
                attempts_next = '0;
                crc_next = CRC_INIT;
                pos_next = '0;
                bad_next = 1'b0;
                temp_next = '0;
                hum_next = '0;
                res_valid = 1'b1;
                res.status = ST_COMM;
            end
            KIND_RD_FAIL:
            begin
                if (open_reg)
                begin
                    attempts_next = attempts_inc;
                    crc_next = CRC_INIT;
                    pos_next = '0;
                    bad_next = 1'b0;
                    temp_next = '0;
                    hum_next = '0;
                    if (attempts_inc >= max_attempts)
                    begin
                        open_next = 1'b0;
                        attempts_next = '0;
                        res_valid = 1'b1;
                        res.status = ST_COMM;
                    end
                end
            end
            KIND_BYTE:
            begin
                if (open_reg)
                begin
                    pos_next = pos_reg + 3'd1;
                    case (pos_reg)
                        3'd0:
                        begin
                            temp_next = {item.data_byte, 8'h00};
                            crc_next = crc_fed;
                        end
                        3'd1:
                        begin
                            temp_next = {temp_reg[15:8], item.data_byte};
                            crc_next = crc_fed;
                        end
                        3'd2:
                        begin
                            bad_next = (crc_reg != item.data_byte);
                            crc_next = CRC_INIT;
                        end
                        3'd3:
                        begin
                            hum_next = {item.data_byte, 8'h00};
                            crc_next = crc_fed;
                        end
                        3'd4:
                        begin
                            hum_next = {hum_reg[15:8], item.data_byte};
                            crc_next = crc_fed;
                        end
                        default:
                        begin
                            open_next = 1'b0;
                            attempts_next = '0;
                            crc_next = CRC_INIT;
                            pos_next = '0;
                            bad_next = 1'b0;
                            temp_next = '0;
                            hum_next = '0;
                            res_valid = 1'b1;
                            if (bad_reg || (crc_reg != item.data_byte))
                            begin
                                res.status = ST_CRC;
                            end
                            else
                            begin
                                res.status = ST_OK;
                                res.raw_temperature = temp_reg;
                                res.raw_humidity = hum_reg;
                            end
                        end
                    endcase
                    if (pos_reg < LAST_POS && pos_next > LAST_POS)
                    begin
                        pos_next = LAST_POS;
                    end
                end
            end
            default:
            begin
                open_next = open_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            pos_reg <= '0;
            attempts_reg <= '0;
            open_reg <= 1'b0;
            bad_reg <= 1'b0;
            temp_reg <= '0;
            hum_reg <= '0;
        end
        else if (advance)
        begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            attempts_reg <= attempts_next;
            open_reg <= open_next;
            bad_reg <= bad_next;
            temp_reg <= temp_next;
            hum_reg <= hum_next;
        end
    end

endmodule

// ===== rtl/core/sensor_word_crc_frame_checker_core.sv =====
// Top level of the sensor word CRC frame checker with request registers and config port.
// Each accepted request is registered and is processed once the output register is free
// or not stalled; its result, if any, is then loaded into the output register.
// At most one request is accepted per cycle, and none while in_stall is high.
// Reset is asynchronous and active low: frame state clears, the CRC returns to 0xFF,
// and max_read_attempts returns to 3.
module sensor_word_crc_frame_checker_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sfc_pkg::sfc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output sfc_pkg::sfc_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sfc_pkg::*;

    logic       in_valid_reg;
    sfc_in_t    in_item_reg;
    logic       out_valid_reg;
    sfc_out_t   out_data_reg;
    logic [2:0] max_attempts_reg;
    logic       advance;
    logic       accept;
    logic       res_valid;
    sfc_out_t   res;
    logic       reg_hit;

    assign advance = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept = in_valid && !in_stall;
    assign reg_hit = (paddr[2] == REG_MAX_ATTEMPTS);

    sfc_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (in_item_reg),
        .max_attempts (max_attempts_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= MAX_ATTEMPTS_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            max_attempts_reg <= pwdata[2:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_hit)
        begin
            prdata = {29'd0, max_attempts_reg};
        end
    end

    assign pready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

// ===== rtl/core/sfc_checker.sv =====
// Port-level checker for the frame checker core and its bind statement.
`include "assert_macros.svh"

module sfc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input sfc_pkg::sfc_out_t out_data
);
    import sfc_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
    `ASSERT_IMPLY(a_status_legal, clk, rst_n, out_valid, out_data.status == ST_OK || out_data.status == ST_CRC || out_data.status == ST_COMM, "illegal status code")
    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.raw_temperature == 16'd0 && out_data.raw_humidity == 16'd0, "failed result carries data")
    `ASSERT_NEXT(a_stall_clears, clk, rst_n, in_stall && !out_stall, !in_stall || out_valid, "request stalled while output is free")

endmodule

bind sensor_word_crc_frame_checker_core sfc_checker u_sfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== dv/sensor_word_crc_frame_checker_core_tb.sv =====
// Self-checking testbench for the sensor word CRC frame checker: random and directed requests.
module sensor_word_crc_frame_checker_core_tb;
    import sfc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    sfc_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    sfc_out_t    out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sfc_in_t  pending_reqs[$];
    sfc_out_t due_reports[$];
    int       item_total = 0;
    int       error_count = 0;
    int       send_idle_pct = 12;
    int       recv_idle_pct = 65;
    int       hold_left = 0;
    int       hold_asks = 0;
    int       hold_served = 0;

    logic [2:0]  attempt_limit = MAX_ATTEMPTS_RESET;
    logic [7:0]  crc_acc = CRC_INIT;
    logic [2:0]  frame_pos = '0;
    logic [2:0]  attempts = '0;
    logic        meas_open = 1'b0;
    logic        word1_bad = 1'b0;
    logic [15:0] temp_word = '0;
    logic [15:0] hum_word = '0;

    sensor_word_crc_frame_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    function automatic logic [7:0] sensor_crc8(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
        end
        return c;
    endfunction

    task automatic note_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic clear_frame();
        crc_acc = CRC_INIT;
        frame_pos = '0;
        word1_bad = 1'b0;
        temp_word = '0;
        hum_word = '0;
    endtask

    task automatic post_report(input status_t st, input logic [15:0] t, input logic [15:0] h);
        sfc_out_t r;
        r.status = st;
        r.raw_temperature = t;
        r.raw_humidity = h;
        due_reports.push_back(r);
    endtask

    task automatic track_frame(input sfc_in_t req);
        logic bad;
        case (req.kind)
            KIND_START:
            begin
                meas_open = 1'b1;
                attempts = '0;
                clear_frame();
            end
            KIND_CMD_FAIL:
            begin
                meas_open = 1'b0;
                attempts = '0;
                clear_frame();
                post_report(ST_COMM, '0, '0);
            end
            KIND_RD_FAIL:
            begin
                if (meas_open)
                begin
                    attempts = attempts + 3'd1;
                    clear_frame();
                    if (attempts >= attempt_limit)
                    begin
                        meas_open = 1'b0;
                        attempts = '0;
                        post_report(ST_COMM, '0, '0);
                    end
                end
            end
            default:
            begin
                if (meas_open)
                begin
                    case (frame_pos)
                        3'd0:
                        begin
                            temp_word = {req.data_byte, 8'h00};
                            crc_acc = sensor_crc8(crc_acc, req.data_byte);
                        end
                        3'd1:
                        begin
                            temp_word[7:0] = req.data_byte;
                            crc_acc = sensor_crc8(crc_acc, req.data_byte);
                        end
                        3'd2:
                        begin
                            word1_bad = (crc_acc != req.data_byte);
                            crc_acc = CRC_INIT;
                        end
                        3'd3:
                        begin
                            hum_word = {req.data_byte, 8'h00};
                            crc_acc = sensor_crc8(crc_acc, req.data_byte);
                        end
                        3'd4:
                        begin
                            hum_word[7:0] = req.data_byte;
                            crc_acc = sensor_crc8(crc_acc, req.data_byte);
                        end
                        default:
                        begin
                            bad = word1_bad || (crc_acc != req.data_byte);
                            if (bad)
                            begin
                                post_report(ST_CRC, '0, '0);
                            end
                            else
                            begin
                                post_report(ST_OK, temp_word, hum_word);
                            end
                            meas_open = 1'b0;
                            attempts = '0;
                            clear_frame();
                        end
                    endcase
                    if (frame_pos != LAST_POS && meas_open)
                    begin
                        frame_pos = frame_pos + 3'd1;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_frame(in_data);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_reqs.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asks)
        begin
            hold_left <= 300;
            hold_served <= hold_asks;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        sfc_out_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    note_error($sformatf("unexpected result status %0d", out_data.status));
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        note_error($sformatf("status got %0d want %0d",
                                             out_data.status, want.status));
                    end
                    if (out_data.raw_temperature !== want.raw_temperature)
                    begin
                        note_error($sformatf("raw_temperature got %h want %h",
                                             out_data.raw_temperature, want.raw_temperature));
                    end
                    if (out_data.raw_humidity !== want.raw_humidity)
                    begin
                        note_error($sformatf("raw_humidity got %h want %h",
                                             out_data.raw_humidity, want.raw_humidity));
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic add_req(input kind_t k, input logic [7:0] b);
        sfc_in_t r;
        r.kind = k;
        r.data_byte = b;
        pending_reqs.push_back(r);
        item_total++;
    endtask

    task automatic push_frame(input logic [15:0] t, input logic [15:0] h, input logic corrupt);
        logic [7:0] bytes [6];
        int idx;
        bytes[0] = t[15:8];
        bytes[1] = t[7:0];
        bytes[2] = sensor_crc8(sensor_crc8(CRC_INIT, bytes[0]), bytes[1]);
        bytes[3] = h[15:8];
        bytes[4] = h[7:0];
        bytes[5] = sensor_crc8(sensor_crc8(CRC_INIT, bytes[3]), bytes[4]);
        if (corrupt)
        begin
            idx = $urandom_range(5);
            bytes[idx] = bytes[idx] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < 6; i++)
        begin
            add_req(KIND_BYTE, bytes[i]);
        end
    endtask

    task automatic push_random_sequence();
        int pick;
        int m;
        int k;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            add_req(KIND_START, 8'($urandom));
            m = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
            repeat (m)
            begin
                k = $urandom_range(5);
                repeat (k) add_req(KIND_BYTE, 8'($urandom));
                add_req(KIND_RD_FAIL, 8'($urandom));
            end
            push_frame(16'($urandom), 16'($urandom), $urandom_range(3) == 0);
        end
        else if (pick < 62)
        begin
            add_req(KIND_START, 8'($urandom));
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(2) == 0)
                begin
                    add_req(KIND_BYTE, 8'($urandom));
                end
                add_req(KIND_RD_FAIL, 8'($urandom));
            end
        end
        else if (pick < 72)
        begin
            add_req(KIND_START, 8'($urandom));
            repeat ($urandom_range(5)) add_req(KIND_BYTE, 8'($urandom));
            add_req(KIND_CMD_FAIL, 8'($urandom));
        end
        else if (pick < 82)
        begin
            add_req(KIND_START, 8'($urandom));
            repeat ($urandom_range(1, 5)) add_req(KIND_BYTE, 8'($urandom));
            add_req(KIND_START, 8'($urandom));
            push_frame(16'($urandom), 16'($urandom), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 4)) add_req(kind_t'($urandom_range(3)), 8'($urandom));
        end
    endtask

    task automatic settle();
        while (pending_reqs.size() != 0 || in_valid || due_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_attempt_limit(input logic [2:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(REG_MAX_ATTEMPTS));
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        attempt_limit = v;
        @(posedge clk);
        if (prdata !== 32'(v) || pready !== 1'b1)
        begin
            note_error($sformatf("max_read_attempts read back %0d want %0d", prdata, v));
        end
    endtask

    task automatic run_random_until(input int goal);
        while (item_total < goal)
        begin
            push_random_sequence();
        end
        settle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_req(KIND_BYTE, 8'h00);
        add_req(KIND_RD_FAIL, 8'hFF);
        add_req(KIND_CMD_FAIL, 8'h00);
        add_req(KIND_START, 8'hFF);
        push_frame(16'h0000, 16'hFFFF, 1'b0);
        add_req(KIND_START, 8'h00);
        add_req(KIND_BYTE, 8'hAA);
        add_req(KIND_START, 8'h55);
        push_frame(16'hBEEF, 16'h0000, 1'b0);
        add_req(KIND_START, 8'h00);
        add_req(KIND_BYTE, 8'hBE);
        add_req(KIND_BYTE, 8'hEF);
        add_req(KIND_BYTE, 8'h93);
        add_req(KIND_BYTE, 8'hFF);
        add_req(KIND_BYTE, 8'hFF);
        add_req(KIND_BYTE, 8'hAC);
        settle();
        run_random_until(450);

        send_idle_pct = 65;
        recv_idle_pct = 12;
        write_attempt_limit(3'd0);
        add_req(KIND_START, 8'h12);
        add_req(KIND_RD_FAIL, 8'h34);
        run_random_until(600);

        write_attempt_limit(3'd7);
        run_random_until(1000);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attempt_limit(3'd1);
        hold_asks++;
        repeat (40) add_req(KIND_CMD_FAIL, 8'($urandom));
        repeat (6)
        begin
            add_req(KIND_START, 8'($urandom));
            push_frame(16'($urandom), 16'($urandom), 1'b0);
        end
        settle();
        run_random_until(1250);

        write_attempt_limit(3'($urandom_range(1, 7)));
        run_random_until(1350);

        repeat (10) @(posedge clk);
        if (due_reports.size() != 0)
        begin
            note_error($sformatf("%0d expected results never arrived", due_reports.size()));
        end
        if (error_count == 0)
        begin
            $display("sensor_word_crc_frame_checker_core regression: pass");
        end
        else
        begin
            $display("sensor_word_crc_frame_checker_core regression: fail");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("sensor_word_crc_frame_checker_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sfc_pkg.sv
rtl/core/sfc_frame.sv
rtl/core/sensor_word_crc_frame_checker_core.sv
rtl/core/sfc_checker.sv
dv/sensor_word_crc_frame_checker_core_tb.sv
